### rtl/can_rx_acceptance_filter_bank_unit_macros.svh
// Assertion macros shared by the acceptance filter bank RTL.
// Included by the modules that carry concurrent assertions; needs nothing else.
`ifndef CAN_RX_ACCEPTANCE_FILTER_BANK_UNIT_MACROS_SVH
`define CAN_RX_ACCEPTANCE_FILTER_BANK_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define CANAF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
// Antecedent implies consequent in the next cycle.
`define CANAF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define CANAF_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define CANAF_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/canaf_pkg.sv
// Package for the CAN receive acceptance filter bank: word types, status codes,
// register indexes and the data byte mask helper. Depends on nothing.
package canaf_pkg;

    localparam int FILTER_ENTRIES_DEF = 32;
    // Width that holds any active entry count up to the largest bank size.
    localparam int ACT_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [5:0]  ENTRIES_RESET = 6'd32;
    localparam logic [3:0]  DLC_MAX       = 4'd8;
    localparam logic [11:0] MASK_ALL      = 12'hFFF;

    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_MODE    = 2'd1;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_INDEX  = 3'd1;
    localparam logic [2:0] STATUS_NOT_NORMAL = 3'd2;
    localparam logic [2:0] STATUS_NO_MATCH   = 3'd3;
    localparam logic [2:0] STATUS_UNBOUND    = 3'd4;

    typedef struct packed {
        logic        cmd;
        logic [4:0]  entry_index;
        logic [10:0] filter_ident;
        logic [10:0] filter_mask;
        logic        filter_rtr;
        logic        has_handler;
        logic [10:0] frame_ident;
        logic [3:0]  frame_dlc;
        logic [63:0] frame_data;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  hit_index;
        logic [10:0] out_ident;
        logic [3:0]  out_dlc;
        logic [63:0] out_data;
    } out_word_t;

    // Returns a mask that keeps the first len bytes of a data word; len is already clamped to 8.
    function automatic logic [63:0] keep_bytes(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < len) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

### rtl/can_rx_acceptance_filter_bank_unit.sv
// CAN receive acceptance filter bank, top level.
// Depends on canaf_pkg and can_rx_acceptance_filter_bank_unit_macros.svh.
//
// Usage: an input word on s_* either writes one filter entry (cmd 0) or
// presents a received standard frame (cmd 1). Every input word yields exactly
// one result word on m_*. Filter entries (identifier and mask) live in a
// synchronous memory; the bound flags are flip-flops that double as valid bits,
// so an entry never written reads as ident 0, mask all ones, unbound.
// The cfg_* channel writes entries_in_use (index 0) and normal_mode (index 1);
// it is always ready and must only be used while no word is in flight.
// A write or a dropped frame goes from the input register through the dispatch
// and done states into the output register. A frame is compared one entry per
// cycle through the memory read port, from entry 0 up, until the first hit or
// until all n entries have missed, n being the active entry count.
// One word is processed at a time; s_ready returns the cycle after the result
// moves into the output register. A result waiting on m_ready does not block
// the next word from being accepted and processed; only its hand-off waits.
// Reset empties the bank, sets entries_in_use to 32 and normal_mode to 0.
`include "can_rx_acceptance_filter_bank_unit_macros.svh"

module can_rx_acceptance_filter_bank_unit #(
    parameter int FILTER_ENTRIES = canaf_pkg::FILTER_ENTRIES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  canaf_pkg::in_word_t                 s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output canaf_pkg::out_word_t                m_data,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [canaf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [canaf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = (FILTER_ENTRIES > 1) ? $clog2(FILTER_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(FILTER_ENTRIES + 1);

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_DISPATCH = 2'd1;
    localparam logic [1:0] S_SCAN     = 2'd2;
    localparam logic [1:0] S_DONE     = 2'd3;

    logic [1:0]                  state_reg, state_next;
    canaf_pkg::in_word_t         in_reg, in_next;
    canaf_pkg::out_word_t        res_reg, res_next;
    canaf_pkg::out_word_t        out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]            cmp_reg, cmp_next;
    logic [5:0]                  eiu_reg, eiu_next;
    logic                        normal_reg, normal_next;
    logic [FILTER_ENTRIES-1:0]   valid_reg, valid_next;

    // Entry memory word: {ident[11:0], mask[11:0]}.
    logic [23:0]                 mem [FILTER_ENTRIES];
    logic                        mem_we;
    logic [ADDR_W-1:0]           wr_addr;
    logic [23:0]                 wr_word;
    logic [ADDR_W-1:0]           rd_addr;
    logic [23:0]                 rd_word_reg;
    logic                        rd_vld_reg;

    logic [canaf_pkg::ACT_W-1:0] eiu_wide;
    logic [canaf_pkg::ACT_W-1:0] n_wide;
    logic [CNT_W-1:0]            active_n;
    logic [CNT_W-1:0]            cmp_inc;
    logic [11:0]                 frame_id12;
    logic [11:0]                 ent_ident;
    logic [11:0]                 ent_mask;
    logic                        hit;
    logic [3:0]                  dlc_clamped;

    assign eiu_wide = {1'b0, eiu_reg};
    assign n_wide   = (eiu_wide > canaf_pkg::ACT_W'(FILTER_ENTRIES))
                      ? canaf_pkg::ACT_W'(FILTER_ENTRIES) : eiu_wide;
    assign active_n = n_wide[CNT_W-1:0];
    assign cmp_inc  = cmp_reg + 1'b1;

    assign wr_addr = ADDR_W'(in_reg.entry_index);
    assign wr_word = {in_reg.filter_rtr, in_reg.filter_ident, 1'b1, in_reg.filter_mask};

    // Received frames carry no RTR bit, so bit 11 of the compared identifier is 0.
    assign frame_id12  = {1'b0, in_reg.frame_ident};
    assign ent_ident   = rd_vld_reg ? rd_word_reg[23:12] : 12'h000;
    assign ent_mask    = rd_vld_reg ? rd_word_reg[11:0] : canaf_pkg::MASK_ALL;
    assign hit         = ((frame_id12 ^ ent_ident) & ent_mask) == 12'h000;
    assign dlc_clamped = (in_reg.frame_dlc > canaf_pkg::DLC_MAX)
                         ? canaf_pkg::DLC_MAX : in_reg.frame_dlc;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;

    always_comb begin
        state_next     = state_reg;
        in_next        = in_reg;
        res_next       = res_reg;
        cmp_next       = cmp_reg;
        valid_next     = valid_reg;
        mem_we         = 1'b0;
        rd_addr        = '0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        eiu_next       = eiu_reg;
        normal_next    = normal_reg;

        if (cfg_valid) begin
            case (cfg_index)
                canaf_pkg::REG_ENTRIES_IN_USE: eiu_next    = cfg_data[5:0];
                canaf_pkg::REG_NORMAL_MODE:    normal_next = cfg_data[0];
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    in_next    = s_data;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                res_next = '0;
                cmp_next = '0;
                state_next = S_DONE;
                if (!in_reg.cmd) begin
                    if (in_reg.has_handler &&
                        (canaf_pkg::ACT_W'(in_reg.entry_index) < n_wide)) begin
                        mem_we              = 1'b1;
                        valid_next[wr_addr] = 1'b1;
                        res_next.status     = canaf_pkg::STATUS_OK;
                    end else begin
                        res_next.status = canaf_pkg::STATUS_BAD_INDEX;
                    end
                end else if (!normal_reg) begin
                    res_next.status = canaf_pkg::STATUS_NOT_NORMAL;
                end else if (active_n == '0) begin
                    res_next.status = canaf_pkg::STATUS_NO_MATCH;
                end else begin
                    rd_addr    = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // Entry cmp_reg is on the memory output; the next one is read now.
                if (hit) begin
                    res_next.hit_index = 5'(cmp_reg);
                    if (rd_vld_reg) begin
                        res_next.status    = canaf_pkg::STATUS_OK;
                        res_next.out_ident = in_reg.frame_ident;
                        res_next.out_dlc   = dlc_clamped;
                        res_next.out_data  = in_reg.frame_data
                                             & canaf_pkg::keep_bytes(dlc_clamped);
                    end else begin
                        res_next.status = canaf_pkg::STATUS_UNBOUND;
                    end
                    state_next = S_DONE;
                end else if (cmp_inc == active_n) begin
                    res_next.status = canaf_pkg::STATUS_NO_MATCH;
                    state_next      = S_DONE;
                end else begin
                    cmp_next = cmp_inc;
                    rd_addr  = ADDR_W'(cmp_inc);
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            eiu_reg       <= canaf_pkg::ENTRIES_RESET;
            normal_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            eiu_reg       <= eiu_next;
            normal_reg    <= normal_next;
        end
        in_reg  <= in_next;
        res_reg <= res_next;
        out_reg <= out_next;
        cmp_reg <= cmp_next;
    end

    // Writes and scans belong to different words, so no read that a scan uses meets
    // a write in the same cycle and the read port needs no forwarding.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_word;
        end
        rd_word_reg <= mem[rd_addr];
        rd_vld_reg  <= valid_reg[rd_addr];
    end

    `CANAF_ASSERT_IMPL(a_scan_in_range, aclk, aresetn, state_reg == S_SCAN, cmp_reg < active_n)
    `CANAF_ASSERT_NEXT(a_write_sets_bound, aclk, aresetn, mem_we, valid_reg[$past(wr_addr)])
    `CANAF_ASSERT_NEXT(a_done_waits, aclk, aresetn, (state_reg == S_DONE) && out_valid_reg && !m_ready, (state_reg == S_DONE) && out_valid_reg)
    `CANAF_ASSERT_IMPL(a_drop_has_no_data, aclk, aresetn, m_valid && (m_data.status != canaf_pkg::STATUS_OK), (m_data.out_data == 64'd0) && (m_data.out_dlc == 4'd0))

endmodule
